>>> sv/ubt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ubt_pkg
// types, request and status codes shared by the port binding table cells
// and the table core
// ----------------------------------------------------------------------------
package ubt_pkg;

	localparam int TABLE_DEPTH_DEF = 16;

	localparam logic [1:0] REQ_REGISTER = 2'd0;
	localparam logic [1:0] REQ_RELEASE  = 2'd1;
	localparam logic [1:0] REQ_LOOKUP   = 2'd2;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_MISS = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [31:0] remote_ip;
		logic [15:0] local_port;
		logic [15:0] remote_port;
		logic [7:0]  mailbox_id;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		logic [7:0] target_id;
	} rsp_t;

	// one binding as held in a cell; also used as the broadcast key
	typedef struct packed {
		logic [31:0] remote_ip;
		logic [15:0] local_port;
		logic [15:0] remote_port;
		logic [7:0]  target;
	} entry_t;

	// lookup result passed cell to cell, newest match wins
	typedef struct packed {
		logic       exact_hit;
		logic [7:0] exact_target;
		logic       port_hit;
		logic [7:0] port_target;
	} carry_t;

	typedef struct packed {
		logic write;
		logic mark;
		logic compact;
	} cell_cmd_t;

endpackage
`default_nettype wire

>>> sv/ubt_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ubt_cell
// one slot of the binding table: holds a binding, appends, drops on release,
// shifts down to close gaps and forwards the lookup result to its neighbor
// ----------------------------------------------------------------------------
module ubt_cell
	import ubt_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire cell_cmd_t cmd,
	input  wire entry_t    key,
	input  wire logic      prev_valid,
	input  wire logic      next_valid,
	input  wire entry_t    next_entry,
	input  wire carry_t    carry_in,
	output logic           valid,
	output entry_t         entry,
	output carry_t         carry,
	output logic           rel_hit,
	output logic           hole
);

	logic   valid_q;
	entry_t entry_q;
	carry_t carry_q;
	logic   exact_match;
	logic   port_match;

	assign rel_hit = valid_q && (entry_q.local_port == key.local_port);
	assign hole    = !valid_q && next_valid;

	// zero in the query is a wildcard
	assign port_match  = valid_q && ((key.local_port == '0) ||
		(entry_q.local_port == key.local_port));
	assign exact_match = port_match &&
		((key.remote_ip == '0) || (entry_q.remote_ip == key.remote_ip)) &&
		((key.remote_port == '0) || (entry_q.remote_port == key.remote_port));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.write) begin
			if (!valid_q && prev_valid) begin
				valid_q <= 1'b1;
			end
		end else if (cmd.mark) begin
			if (rel_hit) begin
				valid_q <= 1'b0;
			end
		end else if (cmd.compact) begin
			// a hole moves up one slot per cycle
			if (hole) begin
				valid_q <= 1'b1;
			end else if (valid_q && !prev_valid) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.write && !valid_q && prev_valid) begin
			entry_q <= key;
		end else if (cmd.compact && hole) begin
			entry_q <= next_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			carry_q <= '0;
		end else begin
			carry_q.exact_hit    <= exact_match || carry_in.exact_hit;
			carry_q.exact_target <= exact_match ? entry_q.target : carry_in.exact_target;
			carry_q.port_hit     <= port_match || carry_in.port_hit;
			carry_q.port_target  <= port_match ? entry_q.target : carry_in.port_target;
		end
	end

	assign valid = valid_q;
	assign entry = entry_q;
	assign carry = carry_q;

endmodule
`default_nettype wire

>>> sv/udp_port_binding_table_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// udp_port_binding_table_core
// ordered table of udp port bindings with register, release and lookup
// ----------------------------------------------------------------------------
// The table is a row of TABLE_DEPTH cells, oldest binding in cell 0. One
// request is handled at a time and gives exactly one response. A release
// drops the matching bindings and then waits for the cells to close the
// gaps: a binding moves down one slot per cycle and can only move once the
// slot below it is empty. During a lookup the match result ripples through
// the cell chain one cell per cycle. The next request can be taken in the
// same cycle as the response is presented. A waiting response does not hold
// the table back until the next one is due.
module udp_port_binding_table_core
	import ubt_pkg::*;
#(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic      req_stall,
	input  wire req_t req,
	output logic      rsp_valid,
	input  wire logic rsp_stall,
	output rsp_t      rsp
);

	localparam int CNT_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(TABLE_DEPTH - 1);

	localparam logic [1:0] S_IDLE    = 2'd0;
	localparam logic [1:0] S_EXEC    = 2'd1;
	localparam logic [1:0] S_COMPACT = 2'd2;
	localparam logic [1:0] S_LOOKUP  = 2'd3;

	logic [1:0]       state_q, state_d;
	req_t             req_q;
	logic             removed_q;
	logic [CNT_W-1:0] cnt_q;
	logic             rsp_valid_q;
	rsp_t             rsp_q;

	cell_cmd_t        cmd;
	entry_t           key;
	logic             accept;
	logic             can_out;
	logic             finish;
	rsp_t             res;
	logic             full;
	carry_t           last_carry;

	logic   [TABLE_DEPTH-1:0] vld;
	logic   [TABLE_DEPTH-1:0] rel_hit;
	logic   [TABLE_DEPTH-1:0] hole;
	entry_t [TABLE_DEPTH-1:0] entries;
	carry_t [TABLE_DEPTH-1:0] carries;

	assign key = '{remote_ip: req_q.remote_ip, local_port: req_q.local_port,
		remote_port: req_q.remote_port, target: req_q.mailbox_id};

	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		logic   prev_v;
		logic   next_v;
		entry_t next_e;
		carry_t cin;

		if (i == 0) begin : g_first
			assign prev_v = 1'b1;
			assign cin    = '0;
		end else begin : g_mid
			assign prev_v = vld[i-1];
			assign cin    = carries[i-1];
		end

		if (i == TABLE_DEPTH - 1) begin : g_last
			assign next_v = 1'b0;
			assign next_e = entries[i];
		end else begin : g_inner
			assign next_v = vld[i+1];
			assign next_e = entries[i+1];
		end

		ubt_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cmd        (cmd),
			.key        (key),
			.prev_valid (prev_v),
			.next_valid (next_v),
			.next_entry (next_e),
			.carry_in   (cin),
			.valid      (vld[i]),
			.entry      (entries[i]),
			.carry      (carries[i]),
			.rel_hit    (rel_hit[i]),
			.hole       (hole[i])
		);
	end

	assign full       = vld[TABLE_DEPTH-1];
	assign last_carry = carries[TABLE_DEPTH-1];
	assign req_stall  = (state_q != S_IDLE);
	assign accept     = req_valid && !req_stall;
	assign can_out    = !rsp_valid_q || !rsp_stall;

	always_comb begin
		cmd           = '0;
		finish        = 1'b0;
		res.status    = ST_MISS;
		res.target_id = '0;
		state_d       = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				unique case (req_q.req_type)
					REQ_REGISTER: begin
						finish = can_out;
						if (full) begin
							res.status = ST_FULL;
						end else begin
							res.status = ST_OK;
							cmd.write  = can_out;
						end
					end
					REQ_RELEASE: begin
						cmd.mark = 1'b1;
						state_d  = S_COMPACT;
					end
					REQ_LOOKUP: begin
						state_d = S_LOOKUP;
					end
					default: begin
						finish = can_out;
					end
				endcase
			end
			S_COMPACT: begin
				cmd.compact = 1'b1;
				finish      = !(|hole) && can_out;
				res.status  = removed_q ? ST_OK : ST_MISS;
			end
			S_LOOKUP: begin
				finish = (cnt_q == CNT_LAST) && can_out;
				if (last_carry.exact_hit) begin
					res.status    = ST_OK;
					res.target_id = last_carry.exact_target;
				end else if (last_carry.port_hit) begin
					res.status    = ST_OK;
					res.target_id = last_carry.port_target;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		if (finish) begin
			state_d = S_IDLE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			removed_q   <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q != S_LOOKUP) begin
				cnt_q <= '0;
			end else if (cnt_q != CNT_LAST) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (cmd.mark) begin
				removed_q <= |rel_hit;
			end
			if (finish) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req;
		end
		if (finish) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// bindings stay packed at the bottom between requests
	a_packed: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |->
		((vld & (vld + {{(TABLE_DEPTH-1){1'b0}}, 1'b1})) == '0))
		else $error("binding table has a gap while idle");

	a_compact_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_COMPACT) |=> ($countones(vld) == $past($countones(vld))))
		else $error("compaction changed the number of bindings");

	a_write_grows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.write |=> ($countones(vld) == $past($countones(vld)) + 1))
		else $error("register did not add exactly one binding");

	a_lookup_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_LOOKUP) |=> $stable(vld))
		else $error("table changed during a lookup");

endmodule
`default_nettype wire
